### sv/tff_pkg.sv
// shared constants and latency helpers for the tangent frame pipeline
package tff_pkg;

  localparam int IN_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF = 30;

  localparam int PM_W   = 31;
  localparam int SQ_W   = 2 * PM_W;
  localparam int NM_W   = SQ_W + 1;
  localparam int SUM_W  = 64;
  localparam int ROOT_W = 32;
  localparam int SREM_W = ROOT_W + 4;
  localparam int DREM_W = ROOT_W + 1;

  function automatic int norm_lat(input int w);
    return $clog2((w > PM_W) ? w : PM_W);
  endfunction

  function automatic int unit_lat(input int w, input int frac);
    return norm_lat(w) + 2 + ROOT_W + (frac + 2) + 1;
  endfunction

endpackage

### sv/tangent_frame_from_direction_core.sv
// tangent frame from direction: top level with input stage, frame math and output skid
// throughput: one beat per cycle; input stalls only when output and skid registers are both full
// reset clears the stage valid bits and the output and skid valids; data registers are not reset
module tangent_frame_from_direction_core #(
  parameter int IN_WIDTH  = tff_pkg::IN_WIDTH_DEF,
  parameter int FRAC_BITS = tff_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // dir_x, dir_y, dir_z
  input  logic [((3*IN_WIDTH+7)/8)*8-1:0]             in_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // east_x, east_y, east_z, north_x, north_y, north_z, up_x, up_y, up_z
  output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0]        out_tdata,
  // zero_error
  output logic                                        out_tuser
);

  localparam int OUT_W       = FRAC_BITS + 2;
  localparam int OUT_TDATA_W = ((9 * OUT_W + 7) / 8) * 8;
  localparam int NL1         = tff_pkg::norm_lat(IN_WIDTH);
  localparam int UL1         = tff_pkg::unit_lat(IN_WIDTH, FRAC_BITS);
  localparam int UL2         = tff_pkg::unit_lat(tff_pkg::NM_W, FRAC_BITS);
  localparam int PD          = UL1 + UL2 + 4;
  localparam int UPD_W       = 4 + 3 * (FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] THR =
    (FRAC_BITS + 1)'((64'd999 << FRAC_BITS) / 64'd1000);

  logic en;
  logic [PD-1:0] v_r;

  // input stage
  logic [2:0][IN_WIDTH-1:0] in_dir;
  logic [2:0][IN_WIDTH-1:0] in_mag;
  logic [2:0]               in_neg;
  logic [2:0][IN_WIDTH-1:0] s0_mag_r;
  logic [2:0]               s0_neg_r;
  logic                     s0_zero;

  assign in_dir = in_tdata[3*IN_WIDTH-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_neg[k] = in_dir[k][IN_WIDTH-1];
      in_mag[k] = in_neg[k] ? (~in_dir[k] + 1'b1) : in_dir[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mag_r <= in_mag;
      s0_neg_r <= in_neg;
    end
  end

  assign s0_zero = (s0_mag_r == '0);

  // up
  logic [2:0][tff_pkg::PM_W-1:0] a_pm;
  logic [2:0][FRAC_BITS:0]       up_q;

  tff_unit #(.W(IN_WIDTH), .FRAC(FRAC_BITS)) u_up (
    .clk   (clk),
    .en    (en),
    .mag_i (s0_mag_r),
    .pm_o  (a_pm),
    .q_o   (up_q)
  );

  logic [2:0][tff_pkg::PM_W-1:0] a_t;
  logic [3:0]                    sg_t;
  logic [2:0]                    neg_t;
  logic                          zero_t;
  logic                          selz;

  tff_delay #(.WIDTH(3 * tff_pkg::PM_W), .DEPTH(UL1 - NL1)) u_dly_a (
    .clk (clk),
    .en  (en),
    .d_i (a_pm),
    .d_o (a_t)
  );

  tff_delay #(.WIDTH(4), .DEPTH(UL1)) u_dly_sg (
    .clk (clk),
    .en  (en),
    .d_i ({s0_zero, s0_neg_r}),
    .d_o (sg_t)
  );

  assign neg_t  = sg_t[2:0];
  assign zero_t = sg_t[3];
  assign selz   = (up_q[2] < THR);

  // north and east operand setup
  logic                          p1_selz_r;
  logic [tff_pkg::PM_W-1:0]      p1_c_r;
  logic [tff_pkg::PM_W-1:0]      p1_o1_r;
  logic [tff_pkg::PM_W-1:0]      p1_o2_r;
  logic [2:0]                    p1_nneg_r;
  logic [2:0][tff_pkg::PM_W-1:0] p1_e_r;
  logic [2:0]                    p1_eneg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_selz_r    <= selz;
      p1_c_r       <= selz ? a_t[2] : a_t[1];
      p1_o1_r      <= a_t[0];
      p1_o2_r      <= selz ? a_t[1] : a_t[2];
      p1_nneg_r[0] <= selz ? (neg_t[0] == neg_t[2]) : (neg_t[0] == neg_t[1]);
      p1_nneg_r[1] <= selz ? (neg_t[1] == neg_t[2]) : 1'b0;
      p1_nneg_r[2] <= selz ? 1'b0 : (neg_t[2] == neg_t[1]);
      p1_e_r[0]    <= selz ? a_t[1] : a_t[2];
      p1_eneg_r[0] <= selz ? !neg_t[1] : neg_t[2];
      p1_e_r[1]    <= selz ? a_t[0] : '0;
      p1_eneg_r[1] <= selz ? neg_t[0] : 1'b0;
      p1_e_r[2]    <= selz ? '0 : a_t[0];
      p1_eneg_r[2] <= selz ? 1'b0 : !neg_t[0];
    end
  end

  // products
  logic                          p2_selz_r;
  logic [tff_pkg::SQ_W-1:0]      p2_pa_r;
  logic [tff_pkg::SQ_W-1:0]      p2_pb_r;
  logic [tff_pkg::SQ_W-1:0]      p2_sq1_r;
  logic [tff_pkg::SQ_W-1:0]      p2_sq2_r;
  logic [2:0]                    p2_nneg_r;
  logic [2:0][tff_pkg::PM_W-1:0] p2_e_r;
  logic [2:0]                    p2_eneg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_selz_r <= p1_selz_r;
      p2_pa_r   <= p1_o1_r * p1_c_r;
      p2_pb_r   <= p1_o2_r * p1_c_r;
      p2_sq1_r  <= p1_o1_r * p1_o1_r;
      p2_sq2_r  <= p1_o2_r * p1_o2_r;
      p2_nneg_r <= p1_nneg_r;
      p2_e_r    <= p1_e_r;
      p2_eneg_r <= p1_eneg_r;
    end
  end

  // north and east vectors before normalizing
  logic [tff_pkg::NM_W-1:0]      sumsq;
  logic [2:0][tff_pkg::NM_W-1:0] p3_n_r;
  logic [2:0][tff_pkg::NM_W-1:0] p3_e_r;
  logic [2:0]                    p3_nneg_r;
  logic [2:0]                    p3_eneg_r;

  assign sumsq = tff_pkg::NM_W'(p2_sq1_r) + tff_pkg::NM_W'(p2_sq2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p3_n_r[0] <= tff_pkg::NM_W'(p2_pa_r);
      p3_n_r[1] <= p2_selz_r ? tff_pkg::NM_W'(p2_pb_r) : sumsq;
      p3_n_r[2] <= p2_selz_r ? sumsq : tff_pkg::NM_W'(p2_pb_r);
      for (int k = 0; k < 3; k++) begin
        p3_e_r[k] <= tff_pkg::NM_W'(p2_e_r[k]);
      end
      p3_nneg_r <= p2_nneg_r;
      p3_eneg_r <= p2_eneg_r;
    end
  end

  logic [2:0][FRAC_BITS:0] north_q;
  logic [2:0][FRAC_BITS:0] east_q;

  tff_unit #(.W(tff_pkg::NM_W), .FRAC(FRAC_BITS)) u_north (
    .clk   (clk),
    .en    (en),
    .mag_i (p3_n_r),
    .pm_o  (),
    .q_o   (north_q)
  );

  tff_unit #(.W(tff_pkg::NM_W), .FRAC(FRAC_BITS)) u_east (
    .clk   (clk),
    .en    (en),
    .mag_i (p3_e_r),
    .pm_o  (),
    .q_o   (east_q)
  );

  logic [UPD_W-1:0] upd_f;
  logic [5:0]       ne_f;

  tff_delay #(.WIDTH(UPD_W), .DEPTH(UL2 + 3)) u_dly_up (
    .clk (clk),
    .en  (en),
    .d_i ({zero_t, neg_t, up_q}),
    .d_o (upd_f)
  );

  tff_delay #(.WIDTH(6), .DEPTH(UL2)) u_dly_ne (
    .clk (clk),
    .en  (en),
    .d_i ({p3_eneg_r, p3_nneg_r}),
    .d_o (ne_f)
  );

  // result assembly
  function automatic logic [OUT_W-1:0] to_fix(input logic neg, input logic [FRAC_BITS:0] q);
    logic [OUT_W-1:0] ext;
    ext = {1'b0, q};
    return neg ? (~ext + 1'b1) : ext;
  endfunction

  logic [2:0][FRAC_BITS:0] up_f;
  logic [2:0]              upneg_f;
  logic                    zero_f;
  logic [OUT_TDATA_W-1:0]  fin_data;

  assign up_f    = upd_f[3*(FRAC_BITS+1)-1:0];
  assign upneg_f = upd_f[3*(FRAC_BITS+1) +: 3];
  assign zero_f  = upd_f[UPD_W-1];

  always_comb begin
    fin_data = '0;
    for (int k = 0; k < 3; k++) begin
      fin_data[k*OUT_W +: OUT_W]     = to_fix(ne_f[3+k], east_q[k]);
      fin_data[(3+k)*OUT_W +: OUT_W] = to_fix(ne_f[k], north_q[k]);
      fin_data[(6+k)*OUT_W +: OUT_W] = to_fix(upneg_f[k], up_f[k]);
    end
  end

  // output register with skid
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_user_r;
  logic                   sk_valid_r;
  logic                   sk_valid_nxt;
  logic [OUT_TDATA_W-1:0] sk_data_r;
  logic                   sk_user_r;
  logic                   push;
  logic                   pop;
  logic                   out_load;
  logic                   sk_load;

  assign en        = !sk_valid_r;
  assign in_tready = en;
  assign push      = v_r[PD-1] && en;
  assign pop       = out_valid_r && out_tready;

  always_comb begin
    out_load      = 1'b0;
    sk_load       = 1'b0;
    out_valid_nxt = out_valid_r;
    sk_valid_nxt  = sk_valid_r;
    if (!out_valid_r || pop) begin
      out_load      = 1'b1;
      out_valid_nxt = sk_valid_r || push;
      sk_valid_nxt  = 1'b0;
    end else if (push) begin
      sk_load      = 1'b1;
      sk_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      if (en) begin
        v_r <= {v_r[PD-2:0], in_tvalid};
      end
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= sk_valid_r ? sk_data_r : fin_data;
      out_user_r <= sk_valid_r ? sk_user_r : zero_f;
    end
    if (sk_load) begin
      sk_data_r <= fin_data;
      sk_user_r <= zero_f;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### sv/tff_shift_cell.sv
// one normalize cell: shifts the whole vector left by a fixed step when its top bits are clear
module tff_shift_cell #(
  parameter int E = 31,
  parameter int S = 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0][E-1:0]   mag_i,
  output logic [2:0][E-1:0]   mag_o
);

  logic [E-1:0]       any_bits;
  logic               hit;
  logic [2:0][E-1:0]  mag_nxt;
  logic [2:0][E-1:0]  mag_r;

  always_comb begin
    any_bits = mag_i[0] | mag_i[1] | mag_i[2];
    hit      = (any_bits[E-1 -: S] == '0);
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k] = hit ? (mag_i[k] << S) : mag_i[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
    end
  end

  assign mag_o = mag_r;

endmodule

### sv/tff_sqrt_cell.sv
// one square root cell: decides one root bit from two radicand bits
module tff_sqrt_cell #(
  parameter int I = 0
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [tff_pkg::SUM_W-1:0]              s_i,
  input  logic [tff_pkg::SREM_W-1:0]             rem_i,
  input  logic [tff_pkg::ROOT_W-1:0]             root_i,
  input  logic [2:0][tff_pkg::PM_W-1:0]          mag_i,
  output logic [tff_pkg::SUM_W-1:0]              s_o,
  output logic [tff_pkg::SREM_W-1:0]             rem_o,
  output logic [tff_pkg::ROOT_W-1:0]             root_o,
  output logic [2:0][tff_pkg::PM_W-1:0]          mag_o
);

  logic [tff_pkg::SREM_W-1:0]    rem_sh;
  logic [tff_pkg::SREM_W-1:0]    trial;
  logic                          ge;
  logic [tff_pkg::SREM_W-1:0]    rem_nxt;
  logic [tff_pkg::ROOT_W-1:0]    root_nxt;
  logic [tff_pkg::SUM_W-1:0]     s_r;
  logic [tff_pkg::SREM_W-1:0]    rem_r;
  logic [tff_pkg::ROOT_W-1:0]    root_r;
  logic [2:0][tff_pkg::PM_W-1:0] mag_r;

  always_comb begin
    rem_sh   = {rem_i[tff_pkg::SREM_W-3:0], s_i[2*I+1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[tff_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      mag_r  <= mag_i;
    end
  end

  assign s_o    = s_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign mag_o  = mag_r;

endmodule

### sv/tff_div_cell.sv
// one divider cell: one quotient bit for each of the three lanes against a shared divisor
module tff_div_cell #(
  parameter bit FIRST = 1'b0,
  parameter int QW    = 32
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [tff_pkg::ROOT_W-1:0]            r_i,
  input  logic [2:0][tff_pkg::DREM_W-1:0]       rem_i,
  input  logic [2:0][QW-1:0]                    q_i,
  output logic [tff_pkg::ROOT_W-1:0]            r_o,
  output logic [2:0][tff_pkg::DREM_W-1:0]       rem_o,
  output logic [2:0][QW-1:0]                    q_o
);

  logic [2:0][tff_pkg::DREM_W-1:0] rem_sh;
  logic [2:0]                      ge;
  logic [2:0][tff_pkg::DREM_W-1:0] rem_nxt;
  logic [2:0][QW-1:0]              q_nxt;
  logic [tff_pkg::ROOT_W-1:0]      r_r;
  logic [2:0][tff_pkg::DREM_W-1:0] rem_r;
  logic [2:0][QW-1:0]              q_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_sh[k]  = FIRST ? rem_i[k] : (rem_i[k] << 1);
      ge[k]      = (rem_sh[k] >= {1'b0, r_i});
      rem_nxt[k] = ge[k] ? (rem_sh[k] - {1'b0, r_i}) : rem_sh[k];
      q_nxt[k]   = {q_i[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= r_i;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign r_o   = r_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

### sv/tff_delay.sv
// shift line that carries side data alongside the arithmetic cells
module tff_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] sh_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign d_o = sh_r[DEPTH-1];

endmodule

### sv/tff_unit.sv
// vector normalizer: prescale cells, squares, square root cells, divider cells, rounding
module tff_unit #(
  parameter int W    = 32,
  parameter int FRAC = 30
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [2:0][W-1:0]               mag_i,
  output logic [2:0][tff_pkg::PM_W-1:0]   pm_o,
  output logic [2:0][FRAC:0]              q_o
);

  localparam int E  = (W > tff_pkg::PM_W) ? W : tff_pkg::PM_W;
  localparam int NS = tff_pkg::norm_lat(W);
  localparam int QW = FRAC + 2;
  localparam int DN = FRAC + 2;

  logic [2:0][E-1:0] nv [NS+1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nv[0][k] = E'(mag_i[k]);
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_norm
    tff_shift_cell #(.E(E), .S(1 << (NS - 1 - j))) u_cell (
      .clk   (clk),
      .en    (en),
      .mag_i (nv[j]),
      .mag_o (nv[j+1])
    );
  end

  logic [2:0][tff_pkg::PM_W-1:0] pm;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pm[k] = nv[NS][k][E-1 -: tff_pkg::PM_W];
    end
  end

  assign pm_o = pm;

  // squares then sum
  logic [2:0][tff_pkg::SQ_W-1:0]  sq_r;
  logic [2:0][tff_pkg::PM_W-1:0]  pm1_r;
  logic [tff_pkg::SUM_W-1:0]      sum_r;
  logic [2:0][tff_pkg::PM_W-1:0]  pm2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= pm[k] * pm[k];
      end
      pm1_r <= pm;
      sum_r <= tff_pkg::SUM_W'(sq_r[0]) + tff_pkg::SUM_W'(sq_r[1])
             + tff_pkg::SUM_W'(sq_r[2]);
      pm2_r <= pm1_r;
    end
  end

  // square root chain
  logic [tff_pkg::SUM_W-1:0]     sv  [tff_pkg::ROOT_W+1];
  logic [tff_pkg::SREM_W-1:0]    srv [tff_pkg::ROOT_W+1];
  logic [tff_pkg::ROOT_W-1:0]    rtv [tff_pkg::ROOT_W+1];
  logic [2:0][tff_pkg::PM_W-1:0] mv  [tff_pkg::ROOT_W+1];

  assign sv[0]  = sum_r;
  assign srv[0] = '0;
  assign rtv[0] = '0;
  assign mv[0]  = pm2_r;

  for (genvar j = 0; j < tff_pkg::ROOT_W; j++) begin : g_sqrt
    tff_sqrt_cell #(.I(tff_pkg::ROOT_W - 1 - j)) u_cell (
      .clk    (clk),
      .en     (en),
      .s_i    (sv[j]),
      .rem_i  (srv[j]),
      .root_i (rtv[j]),
      .mag_i  (mv[j]),
      .s_o    (sv[j+1]),
      .rem_o  (srv[j+1]),
      .root_o (rtv[j+1]),
      .mag_o  (mv[j+1])
    );
  end

  // divider chain, three lanes
  logic [tff_pkg::ROOT_W-1:0]      dr [DN+1];
  logic [2:0][tff_pkg::DREM_W-1:0] dm [DN+1];
  logic [2:0][QW-1:0]              dq [DN+1];

  always_comb begin
    dr[0] = rtv[tff_pkg::ROOT_W];
    for (int k = 0; k < 3; k++) begin
      dm[0][k] = tff_pkg::DREM_W'(mv[tff_pkg::ROOT_W][k]);
      dq[0][k] = '0;
    end
  end

  for (genvar j = 0; j < DN; j++) begin : g_div
    tff_div_cell #(.FIRST(j == 0), .QW(QW)) u_cell (
      .clk   (clk),
      .en    (en),
      .r_i   (dr[j]),
      .rem_i (dm[j]),
      .q_i   (dq[j]),
      .r_o   (dr[j+1]),
      .rem_o (dm[j+1]),
      .q_o   (dq[j+1])
    );
  end

  // round half up; a zero vector stays zero
  logic [2:0][QW-1:0]  qinc;
  logic [2:0][FRAC:0]  q_nxt;
  logic [2:0][FRAC:0]  q_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qinc[k]  = dq[DN][k] + QW'(1);
      q_nxt[k] = (dr[DN] == '0) ? '0 : qinc[k][QW-1:1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule
